// ===== rtl/bbcd_pkg.sv =====
package bbcd_pkg;

  localparam int unsigned BLOCK_W     = 24;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_DWRITE = 2'd1,
    OP_WRITE  = 2'd2,
    OP_FLUSH  = 2'd3
  } op_e;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic done;
  } status_t;

endpackage

// ===== rtl/bbcd_ctrl.sv =====
module bbcd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output bbcd_pkg::cmd_t    cmd_o,
  input  bbcd_pkg::status_t status_i
);
  import bbcd_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_WORK
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_WORK;
        end
      end
      S_WORK: begin
        cmd_o.step = 1'b1;
        if (status_i.done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !cmd_o.step)
    else $error("step issued while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WORK && status_i.done) |=> (state_q == S_IDLE))
    else $error("controller did not return to idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

endmodule

// ===== rtl/bbcd_dpath.sv =====
module bbcd_dpath #(
  parameter int unsigned NUM_SLOTS         = 16,
  parameter int unsigned BLOCK_NUMBER_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bbcd_pkg::cmd_t                cmd_i,
  output bbcd_pkg::status_t             status_o,
  input  logic [1:0]                    opcode_i,
  input  logic [bbcd_pkg::BLOCK_W-1:0]  block_number_i,
  input  logic [bbcd_pkg::SLOT_W-1:0]   slot_i,
  output logic                          result_valid_o,
  output logic [bbcd_pkg::SLOT_W-1:0]   result_slot_o,
  output logic                          hit_o,
  output logic                          needs_fetch_o,
  output logic                          writeback_valid_o,
  output logic [bbcd_pkg::BLOCK_W-1:0]  writeback_block_o,
  output logic                          last_o
);
  import bbcd_pkg::*;

  localparam int unsigned SlotW = $clog2(NUM_SLOTS);
  localparam int unsigned TagW  =
      (BLOCK_NUMBER_BITS < BLOCK_W) ? BLOCK_NUMBER_BITS : BLOCK_W;

  // latched item
  op_e              op_q;
  logic [TagW-1:0]  blk_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SlotW-1:0] idx_q;
  logic [CNT_W-1:0] cnt_q;

  // directory
  logic [TagW-1:0]  tag_q  [NUM_SLOTS];
  logic             valid_q[NUM_SLOTS];
  logic             dirty_q[NUM_SLOTS];
  logic [SlotW-1:0] rank_q [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] match, oldest, vd, above;
  logic                 hit;
  logic [SlotW-1:0]     hit_idx, old_idx, sel, slot_idx;
  logic [SlotW+3:0]     slot_ext, sel_ext;
  logic                 in_range, wr_ok;
  logic [SlotW-1:0]     sel_rank;
  logic [TagW-1:0]      sel_tag;
  logic                 here, any_above;

  logic                 emit, last, newest, set_dirty, clr_dirty, retag;
  logic                 r_hit, r_fetch, r_wbv, r_zero_slot;

  always_comb begin
    hit_idx = '0;
    old_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      match[i]  = valid_q[i] && (tag_q[i] == blk_q);
      oldest[i] = (rank_q[i] == SlotW'(NUM_SLOTS - 1));
      vd[i]     = valid_q[i] && dirty_q[i];
      above[i]  = (SlotW'(i) > idx_q);
      if (match[i]) begin
        hit_idx = SlotW'(i);
      end
      if (oldest[i]) begin
        old_idx = SlotW'(i);
      end
    end
  end

  assign hit       = |match;
  assign any_above = |(vd & above);
  assign slot_ext  = {{SlotW{1'b0}}, slot_q};
  assign slot_idx  = slot_ext[SlotW-1:0];
  assign in_range  = (slot_ext < (SlotW + 4)'(NUM_SLOTS));
  assign wr_ok     = in_range && valid_q[slot_idx];
  assign here      = vd[idx_q];

  always_comb begin
    case (op_q)
      OP_READ:             sel = hit ? hit_idx : old_idx;
      OP_DWRITE, OP_WRITE: sel = slot_idx;
      default:             sel = idx_q;
    endcase
  end

  assign sel_rank = rank_q[sel];
  assign sel_tag  = tag_q[sel];
  assign sel_ext  = {4'b0000, sel};

  always_comb begin
    emit        = 1'b1;
    last        = 1'b1;
    newest      = 1'b0;
    set_dirty   = 1'b0;
    clr_dirty   = 1'b0;
    retag       = 1'b0;
    r_hit       = 1'b0;
    r_fetch     = 1'b0;
    r_wbv       = 1'b0;
    r_zero_slot = 1'b0;
    unique case (op_q)
      OP_READ: begin
        r_hit   = hit;
        r_fetch = !hit;
        r_wbv   = !hit && valid_q[old_idx] && dirty_q[old_idx];
        newest  = !hit;
        retag   = !hit;
        clr_dirty = !hit;
      end
      OP_DWRITE: begin
        newest    = wr_ok;
        set_dirty = wr_ok;
      end
      OP_WRITE: begin
        newest    = wr_ok;
        clr_dirty = wr_ok;
        r_wbv     = wr_ok;
      end
      OP_FLUSH: begin
        emit        = here || !any_above;
        last        = !here || !any_above || (cnt_q == CNT_W'(MAX_RESULTS - 1));
        newest      = here;
        clr_dirty   = here;
        r_wbv       = here;
        r_zero_slot = !here;
      end
      default: emit = 1'b1;
    endcase
  end

  assign status_o.done = emit && last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(opcode_i);
      blk_q  <= block_number_i[TagW-1:0];
      slot_q <= slot_i;
    end
    if (cmd_i.step && retag) begin
      tag_q[sel] <= blk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        valid_q[i] <= 1'b0;
        dirty_q[i] <= 1'b0;
        rank_q[i]  <= SlotW'(i);
      end
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
        cnt_q <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + 1'b1;
        cnt_q <= cnt_q + CNT_W'(here);
        if (retag) begin
          valid_q[sel] <= 1'b1;
        end
        if (set_dirty) begin
          dirty_q[sel] <= 1'b1;
        end else if (clr_dirty) begin
          dirty_q[sel] <= 1'b0;
        end
        if (newest) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (rank_q[i] < sel_rank) begin
              rank_q[i] <= rank_q[i] + 1'b1;
            end
          end
          rank_q[sel] <= '0;
        end
      end
    end
  end

  // result register, one-cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && emit) begin
      result_slot_o     <= r_zero_slot ? '0 :
                           (op_q == OP_DWRITE || op_q == OP_WRITE) ? slot_q :
                           sel_ext[SLOT_W-1:0];
      hit_o             <= r_hit;
      needs_fetch_o     <= r_fetch;
      writeback_valid_o <= r_wbv;
      writeback_block_o <= r_wbv ? BLOCK_W'(sel_tag) : '0;
      last_o            <= last;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(oldest))
    else $error("age ranks lost exactly one oldest slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(match))
    else $error("block cached in more than one slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && op_q == OP_FLUSH) |-> (cnt_q < CNT_W'(MAX_RESULTS)))
    else $error("flush emitted too many write-backs");

endmodule

// ===== rtl/block_buffer_cache_directory.sv =====
// block buffer cache directory
// command channel: drive opcode_i, block_number_i and slot_i with start high;
// the item is taken at the edge where start is high and busy is low.
// result channel: result_valid_o marks each result for exactly one cycle;
// the receiver has no way to hold results back, so it must take them as
// they come. last_o marks the final result of an item.
// read, delayed write and write: the result strobe rises one cycle after
// the accepting edge and busy drops after one working cycle, so a new item
// is taken while the result is shown, giving one item every 2 cycles.
// flush walks the slots one per cycle in index order in the working state,
// at most one write-back per cycle, stopping after the last dirty slot or
// the sixteenth write-back: 1 to NUM_SLOTS working cycles.
// the tag lookup compares all slot tags in parallel in that working cycle.
// reset clears valid and dirty marks at once and sets the highest slot
// oldest; no clearing pass is needed and the block is ready right away.
module block_buffer_cache_directory #(
  parameter int unsigned NUM_SLOTS         = 16,
  parameter int unsigned BLOCK_NUMBER_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode_i,
  input  logic [bbcd_pkg::BLOCK_W-1:0]  block_number_i,
  input  logic [bbcd_pkg::SLOT_W-1:0]   slot_i,
  output logic                          result_valid_o,
  output logic [bbcd_pkg::SLOT_W-1:0]   result_slot_o,
  output logic                          hit_o,
  output logic                          needs_fetch_o,
  output logic                          writeback_valid_o,
  output logic [bbcd_pkg::BLOCK_W-1:0]  writeback_block_o,
  output logic                          last_o
);
  import bbcd_pkg::*;

  cmd_t    cmd;
  status_t status;

  bbcd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_o    (cmd),
    .status_i (status)
  );

  bbcd_dpath #(
    .NUM_SLOTS         (NUM_SLOTS),
    .BLOCK_NUMBER_BITS (BLOCK_NUMBER_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .opcode_i          (opcode_i),
    .block_number_i    (block_number_i),
    .slot_i            (slot_i),
    .result_valid_o    (result_valid_o),
    .result_slot_o     (result_slot_o),
    .hit_o             (hit_o),
    .needs_fetch_o     (needs_fetch_o),
    .writeback_valid_o (writeback_valid_o),
    .writeback_block_o (writeback_block_o),
    .last_o            (last_o)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import bbcd_pkg::*;

  localparam int unsigned N_SLOTS     = 16;
  localparam int unsigned QUIET_TAIL  = 20;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 40;

  typedef struct packed {
    op_e                op;
    logic [BLOCK_W-1:0] blk;
    logic [SLOT_W-1:0]  slt;
  } cache_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               hit;
    logic               fetch;
    logic               wb_valid;
    logic [BLOCK_W-1:0] wb_block;
    logic               last;
  } dir_reply_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         opcode_i = '0;
  logic [BLOCK_W-1:0] block_number_i = '0;
  logic [SLOT_W-1:0]  slot_i = '0;
  logic               result_valid_o;
  logic [SLOT_W-1:0]  result_slot_o;
  logic               hit_o;
  logic               needs_fetch_o;
  logic               writeback_valid_o;
  logic [BLOCK_W-1:0] writeback_block_o;
  logic               last_o;

  block_buffer_cache_directory dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .block_number_i    (block_number_i),
    .slot_i            (slot_i),
    .result_valid_o    (result_valid_o),
    .result_slot_o     (result_slot_o),
    .hit_o             (hit_o),
    .needs_fetch_o     (needs_fetch_o),
    .writeback_valid_o (writeback_valid_o),
    .writeback_block_o (writeback_block_o),
    .last_o            (last_o)
  );

  // shadow copy of the directory
  logic [BLOCK_W-1:0] shadow_tag   [N_SLOTS];
  logic               shadow_valid [N_SLOTS];
  logic               shadow_dirty [N_SLOTS];
  logic [SLOT_W-1:0]  shadow_rank  [N_SLOTS];

  cache_cmd_t pending_cmds [$];
  dir_reply_t expected_replies [$];
  cache_cmd_t drv_cmd;
  dir_reply_t got_reply;
  dir_reply_t want_reply;

  logic item_taken = 1'b0;
  int   idle_left = 0;
  int   mismatches = 0;
  int   items_taken = 0;
  int   replies_seen = 0;
  int   hit_count = 0;
  int   fetch_count = 0;
  int   writeback_count = 0;
  int   longest_flush = 0;
  int   cycle_count;
  logic [BLOCK_W-1:0] block_pool [24];

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic promote_slot(input int s);
    logic [SLOT_W-1:0] r;
    int i;
    r = shadow_rank[s];
    for (i = 0; i < N_SLOTS; i++)
      if (shadow_rank[i] < r) shadow_rank[i] = shadow_rank[i] + 1'b1;
    shadow_rank[s] = '0;
  endtask

  task automatic predict_directory(input op_e op, input logic [BLOCK_W-1:0] blk,
                                   input logic [SLOT_W-1:0] s);
    dir_reply_t r;
    int i;
    int hit_idx;
    int oldest;
    int n;
    int ndirty;
    r = '0;
    r.last = 1'b1;
    case (op)
      OP_READ: begin
        hit_idx = -1;
        for (i = N_SLOTS - 1; i >= 0; i--)
          if (shadow_valid[i] && shadow_tag[i] == blk) hit_idx = i;
        if (hit_idx >= 0) begin
          r.slot = SLOT_W'(hit_idx);
          r.hit  = 1'b1;
          hit_count++;
        end else begin
          oldest = 0;
          for (i = 0; i < N_SLOTS; i++)
            if (shadow_rank[i] > shadow_rank[oldest]) oldest = i;
          r.slot  = SLOT_W'(oldest);
          r.fetch = 1'b1;
          if (shadow_valid[oldest] && shadow_dirty[oldest]) begin
            r.wb_valid = 1'b1;
            r.wb_block = shadow_tag[oldest];
            writeback_count++;
          end
          shadow_tag[oldest]   = blk;
          shadow_valid[oldest] = 1'b1;
          shadow_dirty[oldest] = 1'b0;
          promote_slot(oldest);
          fetch_count++;
        end
        expected_replies.push_back(r);
      end
      OP_DWRITE, OP_WRITE: begin
        r.slot = s;
        if (shadow_valid[s]) begin
          promote_slot(s);
          if (op == OP_DWRITE) begin
            shadow_dirty[s] = 1'b1;
          end else begin
            shadow_dirty[s] = 1'b0;
            r.wb_valid = 1'b1;
            r.wb_block = shadow_tag[s];
            writeback_count++;
          end
        end
        expected_replies.push_back(r);
      end
      default: begin
        ndirty = 0;
        for (i = 0; i < N_SLOTS; i++)
          if (shadow_valid[i] && shadow_dirty[i]) ndirty++;
        if (ndirty > MAX_RESULTS) ndirty = MAX_RESULTS;
        if (ndirty == 0) begin
          expected_replies.push_back(r);
        end else begin
          n = 0;
          for (i = 0; i < N_SLOTS && n < ndirty; i++) begin
            if (shadow_valid[i] && shadow_dirty[i]) begin
              shadow_dirty[i] = 1'b0;
              promote_slot(i);
              r = '0;
              r.slot     = SLOT_W'(i);
              r.wb_valid = 1'b1;
              r.wb_block = shadow_tag[i];
              r.last     = (n == ndirty - 1);
              expected_replies.push_back(r);
              n++;
            end
          end
          writeback_count += n;
          if (n > longest_flush) longest_flush = n;
        end
      end
    endcase
  endtask

  task automatic add_cmd(input op_e op, input logic [BLOCK_W-1:0] blk,
                         input logic [SLOT_W-1:0] s);
    cache_cmd_t c;
    c.op  = op;
    c.blk = blk;
    c.slt = s;
    pending_cmds.push_back(c);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      // item still waiting for the block
    end else if (idle_left != 0 || pending_cmds.size() == 0) begin
      if (idle_left != 0) idle_left <= idle_left - 1;
      start          <= 1'b0;
      opcode_i       <= 2'($urandom_range(0, 3));
      block_number_i <= BLOCK_W'($urandom);
      slot_i         <= SLOT_W'($urandom);
    end else if (pending_cmds.size() >= QUIET_TAIL && $urandom_range(0, 6) == 0) begin
      idle_left <= $urandom_range(0, 16);
      start     <= 1'b0;
    end else begin
      drv_cmd         = pending_cmds.pop_front();
      start          <= 1'b1;
      opcode_i       <= drv_cmd.op;
      block_number_i <= drv_cmd.blk;
      slot_i         <= drv_cmd.slt;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      item_taken <= 1'b0;
      for (int i = 0; i < N_SLOTS; i++) begin
        shadow_tag[i]   = '0;
        shadow_valid[i] = 1'b0;
        shadow_dirty[i] = 1'b0;
        shadow_rank[i]  = SLOT_W'(i);
      end
    end else begin
      if (result_valid_o) begin
        got_reply.slot     = result_slot_o;
        got_reply.hit      = hit_o;
        got_reply.fetch    = needs_fetch_o;
        got_reply.wb_valid = writeback_valid_o;
        got_reply.wb_block = writeback_block_o;
        got_reply.last     = last_o;
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, slot %0d", result_slot_o));
        end else begin
          want_reply = expected_replies.pop_front();
          replies_seen++;
          if (got_reply !== want_reply)
            report_mismatch($sformatf(
              "got/exp slot %0d/%0d hit %b/%b fetch %b/%b wb %b/%b blk %h/%h last %b/%b",
              got_reply.slot, want_reply.slot, got_reply.hit, want_reply.hit,
              got_reply.fetch, want_reply.fetch, got_reply.wb_valid, want_reply.wb_valid,
              got_reply.wb_block, want_reply.wb_block, got_reply.last, want_reply.last));
        end
      end
      if (start && !busy) begin
        predict_directory(op_e'(opcode_i), block_number_i, slot_i);
        items_taken++;
        item_taken <= 1'b1;
      end else begin
        item_taken <= 1'b0;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("block_buffer_cache_directory regression: fail");
    $finish;
  end

  initial begin
    int i;
    int j;
    int r;
    op_e op;
    logic [BLOCK_W-1:0] blk;
    rst_ni          = 1'b0;

    // directed part
    add_cmd(OP_FLUSH,  24'h000000, 4'd0);
    add_cmd(OP_DWRITE, 24'h123456, 4'd15);
    add_cmd(OP_WRITE,  24'hFFFFFF, 4'd0);
    add_cmd(OP_READ,   24'h000000, 4'd15);
    add_cmd(OP_READ,   24'hFFFFFF, 4'd0);
    add_cmd(OP_READ,   24'h000000, 4'd7);
    add_cmd(OP_READ,   24'hFFFFFF, 4'd8);
    add_cmd(OP_DWRITE, 24'h000000, 4'd15);
    add_cmd(OP_DWRITE, 24'hFFFFFF, 4'd14);
    add_cmd(OP_WRITE,  24'h000000, 4'd14);
    add_cmd(OP_WRITE,  24'hFFFFFF, 4'd14);
    add_cmd(OP_FLUSH,  24'hFFFFFF, 4'd15);
    add_cmd(OP_FLUSH,  24'h000000, 4'd0);
    add_cmd(OP_READ,   24'h800000, 4'd0);
    add_cmd(OP_READ,   24'h7FFFFF, 4'd0);
    add_cmd(OP_READ,   24'h000001, 4'd0);
    add_cmd(OP_READ,   24'hAAAAAA, 4'd5);
    add_cmd(OP_READ,   24'h555555, 4'd10);
    add_cmd(OP_DWRITE, 24'h000000, 4'd9);
    add_cmd(OP_DWRITE, 24'h000000, 4'd0);
    add_cmd(OP_WRITE,  24'h000000, 4'd13);
    add_cmd(OP_FLUSH,  24'h000000, 4'd0);

    // random part: a small pool of blocks gives both hits and dirty evictions
    block_pool[0] = 24'h000000;
    block_pool[1] = 24'hFFFFFF;
    for (i = 2; i < 24; i++) block_pool[i] = BLOCK_W'($urandom);
    for (i = 0; i < 91; i++) begin
      if (i == 60) begin
        for (j = 0; j < N_SLOTS; j++) add_cmd(OP_DWRITE, BLOCK_W'($urandom), SLOT_W'(j));
        add_cmd(OP_FLUSH, BLOCK_W'($urandom), SLOT_W'($urandom));
      end
      r = $urandom_range(0, 99);
      if (r < 45) op = OP_READ;
      else if (r < 72) op = OP_DWRITE;
      else if (r < 87) op = OP_WRITE;
      else op = OP_FLUSH;
      if (op == OP_READ && $urandom_range(0, 4) != 0)
        blk = block_pool[$urandom_range(0, 23)];
      else
        blk = BLOCK_W'($urandom);
      add_cmd(op, blk, SLOT_W'($urandom));
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || start) @(posedge clk_i);
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("ran %0d items into %0d results: %0d hits, %0d fetches, %0d write-backs",
             items_taken, replies_seen, hit_count, fetch_count, writeback_count);
    $display("largest flush wrote back %0d slots, %0d mismatches", longest_flush, mismatches);
    if (mismatches == 0) begin
      $display("block_buffer_cache_directory regression: pass");
    end else begin
      $display("block_buffer_cache_directory regression: fail");
    end
    $finish;
  end

endmodule
